FILE: rtl/core/assert_macros.svh
// shared assertion macros for the primer dimer screen
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define PDS_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define PDS_ASSERT_NEXT(name, clk, rstn, trig, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cond)) \
        else $error(msg);

`else

`define PDS_ASSERT(name, clk, rstn, prop, msg)

`define PDS_ASSERT_NEXT(name, clk, rstn, trig, cond, msg)

`endif

`endif

FILE: rtl/core/pds_pkg.sv
package pds_pkg;

    localparam int MAX_PRIMERS_DEF   = 64;
    localparam int PRIMER_LENGTH_DEF = 25;
    localparam int LEN_CAP           = 32;
    localparam int TAIL_MIN          = 5;
    localparam int TAIL_MAX          = 7;
    localparam int BASES_W           = 50;
    localparam int ROW_W             = 64;
    localparam int ROW_IDX_W         = 6;
    localparam int HIT_CNT_W         = 7;
    localparam int TAIL_W            = 3;
    localparam int MM_W              = 2;
    localparam int CFG_IDX_W         = 1;
    localparam int CFG_DATA_W        = 3;

    localparam logic [1:0] COMP_MASK = 2'b01;

    localparam logic [CFG_IDX_W-1:0] REG_TAIL_LENGTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_MISMATCH = 1'b1;

    typedef struct packed {
        logic [BASES_W-1:0] primer_bases;
        logic               last_primer;
    } t_in_req;

    typedef struct packed {
        logic [ROW_IDX_W-1:0] row_index;
        logic [ROW_W-1:0]     row_hits;
        logic [HIT_CNT_W-1:0] hit_count;
        logic                 last_row;
    } t_out_req;

    // row request travelling along the cells
    typedef struct packed {
        logic                 valid;
        logic [ROW_IDX_W-1:0] index;
        logic                 last;
        logic [BASES_W-1:0]   primer;
        logic [ROW_W-1:0]     hits;
        logic [HIT_CNT_W-1:0] hit_count;
    } t_pkt;

    typedef struct packed {
        logic              adv;
        logic              shift;
        logic              copy;
        logic [TAIL_W-1:0] tail;
        logic [MM_W-1:0]   mm;
    } t_ctl;

    // some window of a from base 1 on matches the reverse complement of b's tail
    function automatic logic f_seeds(input logic [BASES_W-1:0] a,
                                     input logic [BASES_W-1:0] b,
                                     input logic [TAIL_W-1:0]  tail,
                                     input logic [MM_W-1:0]    mm,
                                     input int                 len);
        logic [2*(LEN_CAP+TAIL_MAX)-1:0] ax;
        logic [2*LEN_CAP-1:0]            bx;
        logic [TAIL_W-1:0]               tl;
        logic [2:0]                      diff;
        logic                            found;
        found = 1'b0;
        ax = '0;
        ax[BASES_W-1:0] = a;
        bx = '0;
        bx[BASES_W-1:0] = b;
        tl = (tail < TAIL_W'(TAIL_MIN)) ? TAIL_W'(TAIL_MIN) : tail;
        for (int s = 1; s < LEN_CAP; s++) begin
            diff = '0;
            for (int k = 1; k < TAIL_MAX; k++) begin
                if (k < int'(tl) &&
                    ax[2*(s+k) +: 2] != (bx[2*(len-1-k) +: 2] ^ COMP_MASK)) begin
                    diff = diff + 3'd1;
                end
            end
            if ((s + int'(tl) <= len) &&
                (ax[2*s +: 2] == (bx[2*(len-1) +: 2] ^ COMP_MASK)) &&
                (diff <= {1'b0, mm})) begin
                found = 1'b1;
            end
        end
        return found;
    endfunction

endpackage

FILE: rtl/core/pds_cell.sv
module pds_cell #(
    parameter int CELL_IDX      = 0,
    parameter int PRIMER_LENGTH = pds_pkg::PRIMER_LENGTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pds_pkg::t_ctl                i_ctl,
    input  logic                         i_we,
    input  logic [pds_pkg::BASES_W-1:0]  i_wdata,
    input  logic                         i_active,
    input  logic [pds_pkg::BASES_W-1:0]  i_feed,
    output logic [pds_pkg::BASES_W-1:0]  o_feed,
    input  pds_pkg::t_pkt                i_pkt,
    output pds_pkg::t_pkt                o_pkt
);
    import pds_pkg::*;

    logic [BASES_W-1:0] r_store;
    logic [BASES_W-1:0] r_feed;
    t_pkt               r_pkt;
    logic               r_vld;
    t_pkt               n_pkt;
    logic               w_hit;

    always_comb begin
        w_hit = i_pkt.valid && i_active &&
                (f_seeds(i_pkt.primer, r_store, i_ctl.tail, i_ctl.mm, PRIMER_LENGTH) ||
                 f_seeds(r_store, i_pkt.primer, i_ctl.tail, i_ctl.mm, PRIMER_LENGTH));
        n_pkt = i_pkt;
        n_pkt.hits[CELL_IDX] = w_hit;
        n_pkt.hit_count = i_pkt.hit_count + HIT_CNT_W'(w_hit);
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_store <= i_wdata;
        end
        if (i_ctl.copy) begin
            r_feed <= i_we ? i_wdata : r_store;
        end else if (i_ctl.shift) begin
            r_feed <= i_feed;
        end
        if (i_ctl.adv) begin
            r_pkt <= n_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.adv) begin
            r_vld <= i_pkt.valid;
        end
    end

    always_comb begin
        o_pkt       = r_pkt;
        o_pkt.valid = r_vld;
    end

    assign o_feed = r_feed;

endmodule

FILE: rtl/core/primer_dimer_screen_unit.sv
// channel   | direction | handshake               | payload
// primers   | in        | i_in_valid / o_in_ready   | i_in (t_in_req)
// hit rows  | out       | o_out_valid / i_out_ready | o_out (t_out_req)
// config    | in        | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// loading takes one cycle per primer; the last primer starts the row pass
// rows enter the cell row one per cycle while it advances and pass through every cell's
// register and then the output register; each cell checks the row's primer against its own
// a stalled output freezes the whole cell row once a row waits at the end of it
// reset is synchronous and clears control only; stored primers are undefined
// no primer is taken until the last row goes
module primer_dimer_screen_unit #(
    parameter int MAX_PRIMERS   = pds_pkg::MAX_PRIMERS_DEF,
    parameter int PRIMER_LENGTH = pds_pkg::PRIMER_LENGTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  pds_pkg::t_in_req               i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output pds_pkg::t_out_req              o_out,
    input  logic                           i_cfg_we,
    input  logic [pds_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pds_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pds_pkg::*;

    `include "assert_macros.svh"

    localparam int CNT_W = $clog2(MAX_PRIMERS + 1);

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic               r_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_issue;
    logic [TAIL_W-1:0]  r_tail;
    logic [MM_W-1:0]    r_mm;
    t_out_req           r_out;
    logic               r_out_vld;

    logic               w_in_acc;
    logic               w_out_acc;
    logic               w_issue;
    logic               w_adv;
    logic               w_load_out;
    logic [HIT_CNT_W-1:0] w_issue_ext;
    t_ctl               w_ctl;

    logic [BASES_W-1:0] w_feed    [MAX_PRIMERS];
    logic [BASES_W-1:0] w_feed_up [MAX_PRIMERS];
    t_pkt               w_pkt     [MAX_PRIMERS+1];
    logic               w_we      [MAX_PRIMERS];
    logic               w_active  [MAX_PRIMERS];

    assign o_in_ready  = (r_state == ST_LOAD);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_acc   = r_out_vld && i_out_ready;
    assign w_issue     = (r_state == ST_RUN) && (r_issue < r_count);
    assign w_load_out  = !r_out_vld || i_out_ready;
    assign w_adv       = !w_pkt[MAX_PRIMERS].valid || w_load_out;
    assign w_issue_ext = HIT_CNT_W'(r_issue);

    always_comb begin
        w_ctl.adv   = w_adv;
        w_ctl.shift = w_issue && w_adv;
        w_ctl.copy  = w_in_acc && i_in.last_primer;
        w_ctl.tail  = r_tail;
        w_ctl.mm    = r_mm;
    end

    // row request entering the first cell
    always_comb begin
        w_pkt[0].valid     = w_issue;
        w_pkt[0].index     = w_issue_ext[ROW_IDX_W-1:0];
        w_pkt[0].last      = (CNT_W'(r_issue + CNT_W'(1)) == r_count);
        w_pkt[0].primer    = w_feed[0];
        w_pkt[0].hits      = '0;
        w_pkt[0].hit_count = '0;
    end

    for (genvar g = 0; g < MAX_PRIMERS; g++) begin : g_cell
        assign w_we[g]     = w_in_acc && (r_count == CNT_W'(g));
        assign w_active[g] = (r_count > CNT_W'(g));
        if (g == MAX_PRIMERS - 1) begin : g_top
            assign w_feed_up[g] = '0;
        end else begin : g_mid
            assign w_feed_up[g] = w_feed[g+1];
        end

        pds_cell #(
            .CELL_IDX      (g),
            .PRIMER_LENGTH (PRIMER_LENGTH)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_we     (w_we[g]),
            .i_wdata  (i_in.primer_bases),
            .i_active (w_active[g]),
            .i_feed   (w_feed_up[g]),
            .o_feed   (w_feed[g]),
            .i_pkt    (w_pkt[g]),
            .o_pkt    (w_pkt[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_issue <= '0;
        end else begin
            unique case (r_state)
                ST_LOAD: begin
                    if (w_in_acc) begin
                        if (r_count != CNT_W'(MAX_PRIMERS)) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                        if (i_in.last_primer) begin
                            r_state <= ST_RUN;
                            r_issue <= '0;
                        end
                    end
                end
                ST_RUN: begin
                    if (w_issue && w_adv) begin
                        r_issue <= r_issue + CNT_W'(1);
                    end
                    if (w_out_acc && r_out.last_row) begin
                        r_state <= ST_LOAD;
                        r_count <= '0;
                        r_issue <= '0;
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail <= TAIL_W'(TAIL_MIN);
            r_mm   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_TAIL_LENGTH:  r_tail <= i_cfg_data[TAIL_W-1:0];
                REG_MAX_MISMATCH: r_mm   <= i_cfg_data[MM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_pkt[MAX_PRIMERS].valid && w_load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pkt[MAX_PRIMERS].valid && w_load_out) begin
            r_out.row_index <= w_pkt[MAX_PRIMERS].index;
            r_out.row_hits  <= w_pkt[MAX_PRIMERS].hits;
            r_out.hit_count <= w_pkt[MAX_PRIMERS].hit_count;
            r_out.last_row  <= w_pkt[MAX_PRIMERS].last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    `PDS_ASSERT(a_no_row_while_loading, i_clk, i_rst_n,
                o_in_ready |-> !o_out_valid, "row pending during load")
    `PDS_ASSERT_NEXT(a_reload_after_last, i_clk, i_rst_n,
                     w_out_acc && r_out.last_row, o_in_ready, "no reload after last row")
    `PDS_ASSERT(a_hit_bound, i_clk, i_rst_n,
                o_out_valid |-> (HIT_CNT_W'(r_count) >= o_out.hit_count),
                "hit count above primer count")
    `PDS_ASSERT(a_issue_bound, i_clk, i_rst_n,
                r_issue <= r_count, "more rows issued than primers")

endmodule

FILE: sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pds_pkg::*;

    localparam int NPRIM         = MAX_PRIMERS_DEF;
    localparam int PLEN          = PRIMER_LENGTH_DEF;
    localparam int SETTLE_CYCLES = MAX_PRIMERS_DEF + 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 50;

    localparam logic [CFG_DATA_W-1:0] TAIL_PLAN [PHASES] =
        '{3'd7, 3'd0, 3'd6, 3'd5, 3'd4, 3'd7, 3'd6, 3'd5};
    localparam logic [CFG_DATA_W-1:0] MM_PLAN [PHASES] =
        '{3'd3, 3'd0, 3'd1, 3'd3, 3'd2, 3'd0, 3'b110, 3'd1};

    class dimer_scoreboard;
        logic [BASES_W-1:0] primers [NPRIM];
        int unsigned        loaded;
        int unsigned        tail_cfg;
        int unsigned        mm_cfg;
        t_out_req           rows_due [$];
        int unsigned        mismatches;

        function new();
            loaded     = 0;
            tail_cfg   = 5;
            mm_cfg     = 0;
            mismatches = 0;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
            if (idx == REG_TAIL_LENGTH) begin
                tail_cfg = data;
            end else begin
                mm_cfg = data[MM_W-1:0];
            end
        endfunction

        // some window of a from base 1 on matches the reverse complement of b's tail
        function bit window_seeds(input logic [BASES_W-1:0] a, input logic [BASES_W-1:0] b);
            int  t;
            int  diff;
            bit  ok;
            t = (tail_cfg < TAIL_MIN) ? TAIL_MIN : int'(tail_cfg);
            for (int s = 1; s + t <= PLEN; s++) begin
                diff = 0;
                ok   = 1'b1;
                for (int k = 0; k < t; k++) begin
                    if (a[2*(s+k) +: 2] != (b[2*(PLEN-1-k) +: 2] ^ COMP_MASK)) begin
                        if (k == 0) begin
                            ok = 1'b0;
                        end else begin
                            diff++;
                        end
                    end
                end
                if (ok && diff <= int'(mm_cfg)) begin
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void note_primer(input t_in_req r);
            logic [ROW_W-1:0] seeded [NPRIM];
            logic [ROW_W-1:0] row;
            t_out_req         exp_row;
            if (loaded < NPRIM) begin
                primers[loaded] = r.primer_bases;
                loaded++;
            end
            if (!r.last_primer) begin
                return;
            end
            for (int i = 0; i < int'(loaded); i++) begin
                seeded[i] = '0;
                for (int j = 0; j < int'(loaded); j++) begin
                    if (window_seeds(primers[i], primers[j])) begin
                        seeded[i][j] = 1'b1;
                    end
                end
            end
            for (int i = 0; i < int'(loaded); i++) begin
                row = seeded[i];
                for (int j = 0; j < int'(loaded); j++) begin
                    if (seeded[j][i]) begin
                        row[j] = 1'b1;
                    end
                end
                exp_row.row_index = ROW_IDX_W'(i);
                exp_row.row_hits  = row;
                exp_row.hit_count = HIT_CNT_W'($countones(row));
                exp_row.last_row  = (i + 1 == int'(loaded));
                rows_due = {rows_due, exp_row};
            end
            loaded = 0;
        endfunction

        function void check_row(input t_out_req got);
            t_out_req exp_row;
            if (rows_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected row: idx %0d hits %h cnt %0d last %b",
                             got.row_index, got.row_hits, got.hit_count, got.last_row);
                end
                return;
            end
            exp_row = rows_due.pop_front();
            if (got.row_index !== exp_row.row_index || got.row_hits !== exp_row.row_hits ||
                got.hit_count !== exp_row.hit_count || got.last_row !== exp_row.last_row) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("row mismatch: exp idx %0d hits %h cnt %0d last %b",
                             exp_row.row_index, exp_row.row_hits, exp_row.hit_count,
                             exp_row.last_row);
                    $display("              got idx %0d hits %h cnt %0d last %b",
                             got.row_index, got.row_hits, got.hit_count, got.last_row);
                end
            end
        endfunction

        function int pending();
            return rows_due.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_req               i_in;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_req              o_out;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    dimer_scoreboard sb = new();
    int unsigned     tx_idle_pct = 26;
    int unsigned     rx_idle_pct = 72;
    int unsigned     items_sent  = 0;
    int unsigned     cycles      = 0;

    primer_dimer_screen_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_row(o_out);
        end
        i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    function automatic logic [BASES_W-1:0] rand_primer();
        return BASES_W'({$urandom(), $urandom()});
    endfunction

    // tail of the result is the reverse complement of a random window of src, with up to flips bases randomised
    function automatic logic [BASES_W-1:0] dimer_partner(input logic [BASES_W-1:0] src,
                                                         input int unsigned flips);
        logic [BASES_W-1:0] p;
        int                 t;
        int                 s;
        int                 k;
        p = rand_primer();
        t = $urandom_range(TAIL_MAX, TAIL_MIN);
        s = $urandom_range(PLEN - t, 1);
        for (k = 0; k < t; k++) begin
            p[2*(PLEN-1-k) +: 2] = src[2*(s+k) +: 2] ^ COMP_MASK;
        end
        repeat (flips) begin
            k = $urandom_range(t - 1, 0);
            p[2*(PLEN-1-k) +: 2] = 2'($urandom());
        end
        return p;
    endfunction

    task automatic send_primer(input t_in_req r);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct && gap < 40) begin
            gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= r;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_primer(r);
        items_sent++;
    endtask

    task automatic send_set(input int unsigned n);
        logic [BASES_W-1:0] members [$];
        t_in_req            r;
        for (int unsigned m = 0; m < n; m++) begin
            if (m > 0 && $urandom_range(99) < 55) begin
                r.primer_bases = dimer_partner(members[$urandom_range(members.size() - 1)],
                                               $urandom_range(3));
            end else begin
                r.primer_bases = rand_primer();
            end
            r.last_primer = (m == n - 1);
            members = {members, r.primer_bases};
            send_primer(r);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] tail,
                             input logic [CFG_DATA_W-1:0] mm);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_TAIL_LENGTH;
        i_cfg_data  <= tail;
        @(posedge i_clk);
        sb.set_reg(REG_TAIL_LENGTH, tail);
        i_cfg_index <= REG_MAX_MISMATCH;
        i_cfg_data  <= mm;
        @(posedge i_clk);
        sb.set_reg(REG_MAX_MISMATCH, mm);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        t_in_req            r;
        logic [BASES_W-1:0] self_dimer;
        int unsigned        phase_start;
        int unsigned        pick;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in        <= '0;
        i_out_ready <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= REG_TAIL_LENGTH;
        i_cfg_data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single-primer sets at both extremes of the bases field
        r.primer_bases = '0;
        r.last_primer  = 1'b1;
        send_primer(r);
        r.primer_bases = '1;
        send_primer(r);

        // primer whose tail pairs with its own window at base 1
        self_dimer = rand_primer();
        for (int k = 0; k < TAIL_MAX; k++) begin
            self_dimer[2*(PLEN-1-k) +: 2] = self_dimer[2*(1+k) +: 2] ^ COMP_MASK;
        end
        r.last_primer  = 1'b0;
        r.primer_bases = '0;
        send_primer(r);
        r.primer_bases = '1;
        send_primer(r);
        r.primer_bases = self_dimer;
        send_primer(r);
        r.primer_bases = dimer_partner(self_dimer, 0);
        send_primer(r);
        r.primer_bases = dimer_partner(self_dimer, 1);
        send_primer(r);
        r.primer_bases = dimer_partner(self_dimer, 3);
        send_primer(r);
        r.primer_bases = rand_primer();
        r.last_primer  = 1'b1;
        send_primer(r);
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase == 3) begin
                tx_idle_pct = 72;
                rx_idle_pct = 26;
            end else if (phase == 6) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            configure(TAIL_PLAN[phase], MM_PLAN[phase]);
            phase_start = items_sent;
            if (phase == 2) begin
                send_set(NPRIM);
            end else if (phase == 5) begin
                // store overflow: the extra primers are dropped
                send_set(NPRIM + 6);
            end
            while (items_sent - phase_start < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                send_set(pick < 80 ? $urandom_range(6, 1) : $urandom_range(16, 7));
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
